FILE: hw/rtl/ooq_pkg.sv
// Package for the ordered offer queue.
// Holds the order-mode and action codes and the command struct that the
// top level hands to every cell. No dependencies.
`timescale 1ns / 1ps

package ooq_pkg;

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_MIN   = 2'd1;
	localparam logic [1:0] MODE_MAX   = 2'd2;
	localparam logic [1:0] MODE_HEAD  = 2'd3;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Command broadcast along the row of cells for one accepted item.
	typedef struct packed {
		logic       ins_tail;
		logic       ins_sort;
		logic       remove;
		logic [1:0] mode;
	} ooq_cmd_t;

endpackage

FILE: hw/rtl/ordered_offer_queue.sv
// Top level of the ordered offer queue: handshakes, count and the row of cells.
// Depends on ooq_pkg and ooq_cell.
//
//  channel   | direction | tdata (low bit up)           | tuser (low bit up)
//  s_axis    | in        | offer_tag, pref_value        | action, eval_ok
//  m_axis    | out       | removed_tag, entry_count     | removed_valid, insert_dropped
//  cfg       | in        | cfg_wdata = order_mode, written when cfg_we is high
//
// The row of cells places an insert or pops the head in the cycle of acceptance,
// the position search rippling along the cells.
// The result is registered and appears the cycle after acceptance.
// Reset clears the count, the order mode and the output valid; cell contents
// are not reset. An item is held off while a result waits and m_axis_tready is low.
`timescale 1ns / 1ps

module ordered_offer_queue #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TAG_BITS    = 16,
	parameter int VALUE_BITS  = 32,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
	localparam int S_DATA_W   = ((TAG_BITS + VALUE_BITS + 7) / 8) * 8,
	localparam int M_DATA_W   = ((TAG_BITS + CNT_W + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,   // offer_tag, pref_value
	input  logic [1:0]          s_axis_tuser,   // action, eval_ok
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,   // removed_tag, entry_count
	output logic [1:0]          m_axis_tuser,   // removed_valid, insert_dropped
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata
);
	import ooq_pkg::*;

	logic [1:0]          mode_q;
	logic [CNT_W-1:0]    count_q;
	logic                m_valid_q;
	logic [TAG_BITS-1:0] m_tag_q;
	logic [CNT_W-1:0]    m_count_q;
	logic                m_rvalid_q;
	logic                m_drop_q;

	logic                         s_acc;
	logic                         in_action;
	logic                         in_ok;
	logic [TAG_BITS-1:0]          in_tag;
	logic signed [VALUE_BITS-1:0] in_value;
	logic                         is_full;
	logic                         is_empty;
	logic                         do_insert;
	logic                         do_remove;
	ooq_cmd_t                     cmd;

	logic [TAG_BITS-1:0]          cell_tag   [QUEUE_DEPTH];
	logic signed [VALUE_BITS-1:0] cell_value [QUEUE_DEPTH];
	logic                         cell_ok    [QUEUE_DEPTH];
	logic                         pre        [QUEUE_DEPTH+1];

	assign in_action = s_axis_tuser[0];
	assign in_ok     = s_axis_tuser[1];
	assign in_tag    = s_axis_tdata[TAG_BITS-1:0];
	assign in_value  = s_axis_tdata[TAG_BITS+VALUE_BITS-1:TAG_BITS];

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	assign is_full   = count_q == CNT_W'(QUEUE_DEPTH);
	assign is_empty  = count_q == '0;
	assign do_insert = s_acc && (in_action == ACT_INSERT) && !is_full;
	assign do_remove = s_acc && (in_action == ACT_REMOVE) && !is_empty;

	always_comb begin
		cmd.mode     = mode_q;
		cmd.remove   = do_remove;
		cmd.ins_tail = do_insert && (!in_ok || mode_q == MODE_FIRST);
		cmd.ins_sort = do_insert && in_ok && (mode_q != MODE_FIRST);
	end

	assign pre[0] = 1'b1;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [TAG_BITS-1:0]          l_tag, r_tag;
		logic signed [VALUE_BITS-1:0] l_value, r_value;
		logic                         l_ok, r_ok;

		if (i == 0) begin : g_first
			assign l_tag   = cell_tag[i];
			assign l_value = cell_value[i];
			assign l_ok    = cell_ok[i];
		end else begin : g_mid_l
			assign l_tag   = cell_tag[i-1];
			assign l_value = cell_value[i-1];
			assign l_ok    = cell_ok[i-1];
		end

		// The last cell has no right neighbour; after a pop it is no longer held.
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_tag   = cell_tag[i];
			assign r_value = cell_value[i];
			assign r_ok    = cell_ok[i];
		end else begin : g_mid_r
			assign r_tag   = cell_tag[i+1];
			assign r_value = cell_value[i+1];
			assign r_ok    = cell_ok[i+1];
		end

		ooq_cell #(
			.CELL_IDX  (i),
			.TAG_BITS  (TAG_BITS),
			.VALUE_BITS(VALUE_BITS),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.new_tag    (in_tag),
			.new_value  (in_value),
			.new_ok     (in_ok),
			.left_tag   (l_tag),
			.left_value (l_value),
			.left_ok    (l_ok),
			.right_tag  (r_tag),
			.right_value(r_value),
			.right_ok   (r_ok),
			.pre_in     (pre[i]),
			.pre_out    (pre[i+1]),
			.tag        (cell_tag[i]),
			.value      (cell_value[i]),
			.ok         (cell_ok[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_FIRST;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_remove) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (s_acc) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_tag_q    <= do_remove ? cell_tag[0] : '0;
			m_rvalid_q <= do_remove;
			m_drop_q   <= (in_action == ACT_INSERT) && is_full;
			if (do_insert) begin
				m_count_q <= count_q + CNT_W'(1);
			end else if (do_remove) begin
				m_count_q <= count_q - CNT_W'(1);
			end else begin
				m_count_q <= count_q;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = M_DATA_W'({m_count_q, m_tag_q});
	assign m_axis_tuser  = {m_drop_q, m_rvalid_q};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_count_reported: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> m_count_q == count_q)
		else $error("reported count differs from held count");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && in_action == ACT_INSERT && is_full |=> m_drop_q && $stable(count_q))
		else $error("insert into full queue not dropped");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(m_drop_q && m_rvalid_q))
		else $error("removed and dropped flagged together");
`endif

endmodule

FILE: hw/rtl/ooq_cell.sv
// One cell of the ordered offer queue: holds a single entry.
// Depends on ooq_pkg for the command struct and mode codes.
`timescale 1ns / 1ps

module ooq_cell #(
	parameter int CELL_IDX   = 0,
	parameter int TAG_BITS   = 16,
	parameter int VALUE_BITS = 32,
	parameter int CNT_W      = 7
) (
	input  logic                         clk,
	input  ooq_pkg::ooq_cmd_t            cmd,
	input  logic [CNT_W-1:0]             count,
	input  logic [TAG_BITS-1:0]          new_tag,
	input  logic signed [VALUE_BITS-1:0] new_value,
	input  logic                         new_ok,
	input  logic [TAG_BITS-1:0]          left_tag,
	input  logic signed [VALUE_BITS-1:0] left_value,
	input  logic                         left_ok,
	input  logic [TAG_BITS-1:0]          right_tag,
	input  logic signed [VALUE_BITS-1:0] right_value,
	input  logic                         right_ok,
	input  logic                         pre_in,
	output logic                         pre_out,
	output logic [TAG_BITS-1:0]          tag,
	output logic signed [VALUE_BITS-1:0] value,
	output logic                         ok
);
	import ooq_pkg::*;

	logic [TAG_BITS-1:0]          tag_q;
	logic signed [VALUE_BITS-1:0] value_q;
	logic                         ok_q;
	logic                         held;
	logic                         beaten;
	logic                         at_tail;

	assign held    = count > CNT_W'(CELL_IDX);
	assign at_tail = count == CNT_W'(CELL_IDX);

	always_comb begin
		case (cmd.mode)
			MODE_MIN: beaten = new_value > value_q;
			MODE_MAX: beaten = new_value < value_q;
			default:  beaten = 1'b0;
		endcase
	end

	// The new entry sinks past this cell only if it and every cell ahead of
	// it are held, evaluated and strictly beaten.
	assign pre_out = pre_in & held & ok_q & beaten;

	always_ff @(posedge clk) begin
		if (cmd.remove) begin
			tag_q   <= right_tag;
			value_q <= right_value;
			ok_q    <= right_ok;
		end else if (cmd.ins_tail && at_tail) begin
			tag_q   <= new_tag;
			value_q <= new_value;
			ok_q    <= new_ok;
		end else if (cmd.ins_sort && !pre_out) begin
			if (pre_in) begin
				tag_q   <= new_tag;
				value_q <= new_value;
				ok_q    <= new_ok;
			end else begin
				tag_q   <= left_tag;
				value_q <= left_value;
				ok_q    <= left_ok;
			end
		end
	end

	assign tag   = tag_q;
	assign value = value_q;
	assign ok    = ok_q;

endmodule
